// ----- design/bracket_match_checker_core_macros.svh -----
// Assertion macros for the bracket match checker core.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef BRACKET_MATCH_CHECKER_CORE_MACROS_SVH
`define BRACKET_MATCH_CHECKER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BMC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bmc: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BMC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bmc: next-cycle check failed");

`endif

// ----- design/bmc_pkg.sv -----
// Shared types and constants for the bracket match checker core.
// No dependencies; used by bracket_match_checker_core.
package bmc_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int AW          = $clog2(STACK_DEPTH);
	localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
	localparam int LINE_W      = 24;
	localparam int COL_W       = 16;

	localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
	localparam logic [COL_W-1:0]  COL_MAX  = {COL_W{1'b1}};

	localparam logic        OP_CHAR    = 1'b0;
	localparam logic        OP_END     = 1'b1;

	localparam logic [15:0] CH_LF      = 16'h000A;
	localparam logic [15:0] CH_LROUND  = 16'h0028;
	localparam logic [15:0] CH_RROUND  = 16'h0029;
	localparam logic [15:0] CH_LSQUARE = 16'h005B;
	localparam logic [15:0] CH_RSQUARE = 16'h005D;

	localparam logic [2:0] KIND_EXTRA    = 3'd0;
	localparam logic [2:0] KIND_MISMATCH = 3'd1;
	localparam logic [2:0] KIND_UNCLOSED = 3'd2;
	localparam logic [2:0] KIND_OVERFLOW = 3'd3;
	localparam logic [2:0] KIND_DONE     = 3'd4;

	typedef struct packed {
		logic              square;
		logic [LINE_W-1:0] line;
		logic [COL_W-1:0]  column;
	} opener_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic              bracket_square;
		logic [LINE_W-1:0] at_line;
		logic [COL_W-1:0]  at_column;
		logic              partner_square;
		logic [LINE_W-1:0] partner_line;
		logic [COL_W-1:0]  partner_column;
		logic              last;
	} res_t;

endpackage

// ----- design/bmc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- design/bracket_match_checker_core.sv -----
// Bracket match checker core: line/column tracking and bracket stack.
// Depends on bmc_pkg, bmc_ram and bracket_match_checker_core_macros.svh.
//
// Usage: feed a script one UTF-16 code unit per input transfer (op = 0),
// then one end transfer (op = 1). Each input transfer moves op and
// char_code on in_valid/in_ready; each result transfer moves one report
// on out_valid/out_ready, with last marking the final report of an item.
// Ordinary characters, newlines and fitting openers need only the idle
// state. A closer pops and reads the stack top from the RAM (registered
// read data) and compares it in the pop state; a mismatch, an extra
// closer or an overflowing opener reports through the emit state. The end
// item walks the stack bottom up, a read and a drain-emit state per open
// entry, then the done state for the done record. Results sit in a
// one-entry output register; an item that gives no result is still taken
// while a report waits there, and a stalled receiver holds the core in its
// emit, drain-emit or done state. Reset puts line at 1, column at 0 and
// the stack empty; stack contents need no clearing pass.
`include "bracket_match_checker_core_macros.svh"

module bracket_match_checker_core
	import bmc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              op,
	input  logic [15:0]       char_code,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        kind,
	output logic              bracket_square,
	output logic [LINE_W-1:0] at_line,
	output logic [COL_W-1:0]  at_column,
	output logic              partner_square,
	output logic [LINE_W-1:0] partner_line,
	output logic [COL_W-1:0]  partner_column,
	output logic              last
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_POP   = 6'b000010,
		ST_EMIT  = 6'b000100,
		ST_DRD   = 6'b001000,
		ST_DEMIT = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t            state_q, state_d;
	logic [LINE_W-1:0] line_q, line_d, line_inc;
	logic [COL_W-1:0]  col_q, col_d, col_inc;
	logic [LVL_W-1:0]  level_q, level_d, lvl_dec, idx_nxt;
	logic [AW-1:0]     idx_q, idx_d;
	logic              out_valid_q, out_vld_d, out_free;
	res_t              pend_q, pend_d, out_q, out_d;

	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	opener_t           ram_wdata, ram_rdata;

	bmc_ram #(
		.WIDTH($bits(opener_t)),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Saturating position counters and stack index arithmetic.
	assign line_inc = (line_q == LINE_MAX) ? line_q : line_q + LINE_W'(1);
	assign col_inc  = (col_q == COL_MAX) ? col_q : col_q + COL_W'(1);
	assign lvl_dec  = level_q - LVL_W'(1);
	assign idx_nxt  = LVL_W'(idx_q) + LVL_W'(1);

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d   = state_q;
		line_d    = line_q;
		col_d     = col_q;
		level_d   = level_q;
		idx_d     = idx_q;
		pend_d    = pend_q;
		out_d     = out_q;
		out_vld_d = out_valid_q && !out_ready;
		ram_we    = 1'b0;
		ram_waddr = level_q[AW-1:0];
		ram_wdata = '{square: (char_code == CH_LSQUARE), line: line_q, column: col_inc};
		ram_re    = 1'b0;
		ram_raddr = lvl_dec[AW-1:0];

		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (op == OP_END) begin
						if (level_q == '0) begin
							state_d = ST_DONE;
						end else begin
							// start the drain at the bottom entry
							ram_re    = 1'b1;
							ram_raddr = '0;
							idx_d     = '0;
							state_d   = ST_DRD;
						end
					end else begin
						case (char_code)
							CH_LF: begin
								line_d = line_inc;
								col_d  = '0;
							end
							CH_LROUND, CH_LSQUARE: begin
								col_d = col_inc;
								if (level_q == LVL_W'(STACK_DEPTH)) begin
									pend_d  = '{kind: KIND_OVERFLOW,
										bracket_square: (char_code == CH_LSQUARE),
										at_line: line_q, at_column: col_inc,
										partner_square: 1'b0, partner_line: '0,
										partner_column: '0, last: 1'b1};
									state_d = ST_EMIT;
								end else begin
									ram_we  = 1'b1;
									level_d = level_q + LVL_W'(1);
								end
							end
							CH_RROUND, CH_RSQUARE: begin
								col_d  = col_inc;
								pend_d = '{kind: KIND_EXTRA,
									bracket_square: (char_code == CH_RSQUARE),
									at_line: line_q, at_column: col_inc,
									partner_square: 1'b0, partner_line: '0,
									partner_column: '0, last: 1'b1};
								if (level_q == '0) begin
									state_d = ST_EMIT;
								end else begin
									// pop now, compare against the top next cycle
									pend_d.kind = KIND_MISMATCH;
									ram_re      = 1'b1;
									level_d     = lvl_dec;
									state_d     = ST_POP;
								end
							end
							default: begin
								col_d = col_inc;
							end
						endcase
					end
				end
			end
			ST_POP: begin
				if (ram_rdata.square != pend_q.bracket_square) begin
					pend_d.partner_square = ram_rdata.square;
					pend_d.partner_line   = ram_rdata.line;
					pend_d.partner_column = ram_rdata.column;
					state_d               = ST_EMIT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_vld_d = 1'b1;
					out_d     = pend_q;
					state_d   = ST_IDLE;
				end
			end
			ST_DRD: begin
				state_d = ST_DEMIT;
			end
			ST_DEMIT: begin
				// read data holds while no new read is issued
				if (out_free) begin
					out_vld_d = 1'b1;
					out_d     = '{kind: KIND_UNCLOSED,
						bracket_square: ram_rdata.square,
						at_line: ram_rdata.line, at_column: ram_rdata.column,
						partner_square: 1'b0, partner_line: '0,
						partner_column: '0, last: 1'b0};
					if (idx_nxt == level_q) begin
						state_d = ST_DONE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = idx_nxt[AW-1:0];
						idx_d     = idx_nxt[AW-1:0];
						state_d   = ST_DRD;
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_vld_d = 1'b1;
					out_d     = '{kind: KIND_DONE, bracket_square: 1'b0,
						at_line: '0, at_column: '0, partner_square: 1'b0,
						partner_line: '0, partner_column: '0, last: 1'b1};
					line_d    = LINE_W'(1);
					col_d     = '0;
					level_d   = '0;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			line_q      <= LINE_W'(1);
			col_q       <= '0;
			level_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			line_q      <= line_d;
			col_q       <= col_d;
			level_q     <= level_d;
			idx_q       <= idx_d;
			out_valid_q <= out_vld_d;
		end
	end

	// Payload: pending report and output register.
	always_ff @(posedge clk) begin
		pend_q <= pend_d;
		out_q  <= out_d;
	end

	assign out_valid      = out_valid_q;
	assign kind           = out_q.kind;
	assign bracket_square = out_q.bracket_square;
	assign at_line        = out_q.at_line;
	assign at_column      = out_q.at_column;
	assign partner_square = out_q.partner_square;
	assign partner_line   = out_q.partner_line;
	assign partner_column = out_q.partner_column;
	assign last           = out_q.last;

	`BMC_ASSERT_SAME(a_level_bound, 1'b1, level_q <= LVL_W'(STACK_DEPTH))
	`BMC_ASSERT_SAME(a_drain_idx, state_q == ST_DRD, LVL_W'(idx_q) < level_q)
	`BMC_ASSERT_NEXT(a_done_clears, (state_q == ST_DONE) && out_free,
		(level_q == '0) && (line_q == LINE_W'(1)) && out_valid_q && out_q.last)

endmodule

// ----- dv/bracket_match_checker_core_tb.sv -----
// Self-checking testbench for bracket_match_checker_core: streams scripts of
// UTF-16 characters and checks every report against a bracket-stack predictor.
// Depends on bmc_pkg and the core RTL.
module bracket_match_checker_core_tb;
	import bmc_pkg::*;

	class bracket_scoreboard;
		logic [LINE_W-1:0] line_no;
		logic [COL_W-1:0]  col_no;
		opener_t           openers[STACK_DEPTH];
		int                open_cnt;
		res_t              awaited[$];
		int                errors;

		function new();
			errors = 0;
			clear_position();
		endfunction

		function void clear_position();
			line_no = LINE_W'(1);
			col_no = '0;
			open_cnt = 0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		task report(string msg);
			if (errors < 40)
				$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		function void post_report(logic [2:0] k, logic sq, logic [LINE_W-1:0] ln,
				logic [COL_W-1:0] cl, opener_t partner, logic lst);
			res_t r;
			r.kind = k;
			r.bracket_square = sq;
			r.at_line = ln;
			r.at_column = cl;
			r.partner_square = partner.square;
			r.partner_line = partner.line;
			r.partner_column = partner.column;
			r.last = lst;
			awaited = {awaited, r};
		endfunction

		// Advance the predicted position and stack by one accepted transfer.
		function void note_transfer(logic o, logic [15:0] c);
			logic    sq;
			opener_t top;
			opener_t none;
			none = '0;
			if (o == OP_END) begin
				for (int i = 0; i < open_cnt; i++)
					post_report(KIND_UNCLOSED, openers[i].square, openers[i].line,
						openers[i].column, none, 1'b0);
				post_report(KIND_DONE, 1'b0, '0, '0, none, 1'b1);
				clear_position();
				return;
			end
			if (c == CH_LF) begin
				if (line_no != LINE_MAX)
					line_no++;
				col_no = '0;
				return;
			end
			if (col_no != COL_MAX)
				col_no++;
			if (c == CH_LROUND || c == CH_LSQUARE) begin
				sq = (c == CH_LSQUARE);
				if (open_cnt < STACK_DEPTH) begin
					openers[open_cnt].square = sq;
					openers[open_cnt].line = line_no;
					openers[open_cnt].column = col_no;
					open_cnt++;
				end else begin
					post_report(KIND_OVERFLOW, sq, line_no, col_no, none, 1'b1);
				end
			end else if (c == CH_RROUND || c == CH_RSQUARE) begin
				sq = (c == CH_RSQUARE);
				if (open_cnt == 0) begin
					post_report(KIND_EXTRA, sq, line_no, col_no, none, 1'b1);
				end else begin
					open_cnt--;
					top = openers[open_cnt];
					if (top.square != sq)
						post_report(KIND_MISMATCH, sq, line_no, col_no, top, 1'b1);
				end
			end
		endfunction

		task compare_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
		endtask

		task check_report(res_t got);
			res_t want;
			if (awaited.size() == 0) begin
				report($sformatf("unexpected report of kind %0d", got.kind));
				return;
			end
			want = awaited.pop_front();
			compare_field("kind", 32'(got.kind), 32'(want.kind));
			compare_field("bracket_square", 32'(got.bracket_square),
				32'(want.bracket_square));
			compare_field("at_line", 32'(got.at_line), 32'(want.at_line));
			compare_field("at_column", 32'(got.at_column), 32'(want.at_column));
			compare_field("partner_square", 32'(got.partner_square),
				32'(want.partner_square));
			compare_field("partner_line", 32'(got.partner_line),
				32'(want.partner_line));
			compare_field("partner_column", 32'(got.partner_column),
				32'(want.partner_column));
			compare_field("last", 32'(got.last), 32'(want.last));
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic              op;
	logic [15:0]       char_code;
	logic              out_valid;
	logic              out_ready;
	logic [2:0]        kind;
	logic              bracket_square;
	logic [LINE_W-1:0] at_line;
	logic [COL_W-1:0]  at_column;
	logic              partner_square;
	logic [LINE_W-1:0] partner_line;
	logic [COL_W-1:0]  partner_column;
	logic              last;

	bracket_scoreboard sb;
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	int rx_hold = 0;
	int items_sent = 0;

	bracket_match_checker_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.char_code      (char_code),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.bracket_square (bracket_square),
		.at_line        (at_line),
		.at_column      (at_column),
		.partner_square (partner_square),
		.partner_line   (partner_line),
		.partner_column (partner_column),
		.last           (last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("FAILURE");
		$finish;
	end

	// Offer one transfer; entered and left at a falling edge.
	task automatic send_item(logic o, logic [15:0] c);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		op = o;
		char_code = c;
		do @(posedge clk); while (!in_ready);
		sb.note_transfer(o, c);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_char(logic [15:0] c);
		send_item(OP_CHAR, c);
	endtask

	task automatic send_end();
		send_item(OP_END, 16'($urandom_range(0, 65535)));
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Any character that is neither a bracket nor a newline.
	function automatic logic [15:0] plain_char();
		logic [15:0] c;
		if ($urandom_range(0, 3) == 0) begin
			case ($urandom_range(0, 4))
				0: c = 16'h000D;
				1: c = 16'h0000;
				2: c = 16'hFFFF;
				3: c = CH_LROUND ^ 16'h0100;
				default: c = CH_RSQUARE ^ 16'h8000;
			endcase
		end else begin
			do c = 16'($urandom_range(0, 65535));
			while (c == CH_LF || c == CH_LROUND || c == CH_RROUND ||
				c == CH_LSQUARE || c == CH_RSQUARE);
		end
		return c;
	endfunction

	// One script: mostly well-nested brackets with random text, some broken closers.
	task automatic run_script();
		int len;
		int pick;
		bit deep;
		bit k;
		bit gen_kind[$];
		deep = ($urandom_range(0, 11) == 0);
		len = deep ? $urandom_range(34, 44) : $urandom_range(1, 30);
		for (int n = 0; n < len; n++) begin
			pick = $urandom_range(0, 99);
			if (deep ? pick < 85 : pick < 30) begin
				k = 1'($urandom_range(0, 1));
				if (gen_kind.size() < STACK_DEPTH)
					gen_kind = {gen_kind, k};
				send_char(k ? CH_LSQUARE : CH_LROUND);
			end else if (pick < 55 && gen_kind.size() > 0) begin
				k = gen_kind[gen_kind.size() - 1];
				gen_kind.delete(gen_kind.size() - 1);
				send_char(k ? CH_RSQUARE : CH_RROUND);
			end else if (pick < 62) begin
				send_char(CH_LF);
			end else if (pick < 70) begin
				if (gen_kind.size() > 0)
					gen_kind.delete(gen_kind.size() - 1);
				send_char($urandom_range(0, 1) ? CH_RSQUARE : CH_RROUND);
			end else begin
				send_char(plain_char());
			end
		end
		if ($urandom_range(0, 9) < 7) begin
			while (gen_kind.size() > 0) begin
				k = gen_kind[gen_kind.size() - 1];
				gen_kind.delete(gen_kind.size() - 1);
				send_char(k ? CH_RSQUARE : CH_RROUND);
			end
		end
		send_end();
	endtask

	initial begin
		res_t got;
		int   stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (rx_hold > 0) begin
				out_ready = 1'b0;
				repeat (rx_hold) @(negedge clk);
				rx_hold = 0;
			end else if (rx_idle_on) begin
				stall = $urandom_range(0, 10);
				if (stall > 0) begin
					out_ready = 1'b0;
					repeat (stall) @(negedge clk);
				end
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			got.kind = kind;
			got.bracket_square = bracket_square;
			got.at_line = at_line;
			got.at_column = at_column;
			got.partner_square = partner_square;
			got.partner_line = partner_line;
			got.partner_column = partner_column;
			got.last = last;
			sb.check_report(got);
			@(negedge clk);
		end
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_CHAR;
		char_code = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// closers on an empty stack, nesting, both mismatches, odd characters
		send_char(CH_RROUND);
		send_char(CH_RSQUARE);
		send_char(CH_LROUND);
		send_char(CH_LSQUARE);
		send_char(CH_RSQUARE);
		send_char(CH_RROUND);
		send_char(CH_LF);
		send_char(16'h000D);
		send_char(CH_LROUND);
		send_char(CH_RSQUARE);
		send_char(CH_LSQUARE);
		send_char(CH_RROUND);
		send_char(16'h0000);
		send_char(16'hFFFF);
		send_char(CH_LROUND);
		send_char(CH_LF);
		send_char(CH_LSQUARE);
		send_item(OP_END, 16'hFFFF);
		send_item(OP_END, 16'h0000);
		wait_drained();

		// fill the stack, overflow it, and hold the receiver off while the
		// end report drains so the core backs up into its input
		for (int i = 0; i < STACK_DEPTH; i++)
			send_char((i % 2) ? CH_LSQUARE : CH_LROUND);
		rx_hold = 80;
		send_char(CH_LROUND);
		send_char(CH_LSQUARE);
		tx_idle_on = 1'b0;
		send_end();
		repeat (6) send_char(CH_RROUND);
		tx_idle_on = 1'b1;
		wait_drained();

		while (items_sent < 480) begin
			tx_idle_on = ($urandom_range(0, 4) != 0);
			rx_idle_on = ($urandom_range(0, 4) != 0);
			run_script();
		end

		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (80) @(negedge clk);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
